FILE: rtl/cmpr_pkg.sv
// Shared types, constants and helper functions for the compressed block decoder.
`default_nettype none

package cmpr_pkg;

  // RGB565 field masks.
  localparam logic [15:0] RED_MASK   = 16'hF800;
  localparam logic [15:0] GREEN_MASK = 16'h07E0;
  localparam logic [15:0] BLUE_MASK  = 16'h001F;

  // Alpha codes.
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // Palette entry codes.
  localparam logic [1:0] SEL_C0  = 2'd0;
  localparam logic [1:0] SEL_C1  = 2'd1;
  localparam logic [1:0] SEL_MIX = 2'd2;
  localparam logic [1:0] SEL_ALT = 2'd3;

  // Reciprocal of three for operands below 1024: floor(x / 3) = (x * 683) >> 11.
  localparam logic [20:0] RECIP3     = 21'd683;
  localparam int          RECIP3_SHR = 11;

  // One 8-bit color, red at index 0, green at 1, blue at 2.
  typedef logic [0:2][7:0] rgb_t;

  // Four-entry palette plus the alpha of the last entry.
  typedef struct packed {
    rgb_t [0:3] entry;
    logic [7:0] alpha3;
  } pal_t;

  // Widen an RGB565 color by a plain left shift of each field.
  function automatic rgb_t expand565(input logic [15:0] c);
    rgb_t       rgb;
    logic [15:0] r_f;
    logic [15:0] g_f;
    logic [15:0] b_f;
    r_f = (c & RED_MASK) >> 11;
    g_f = (c & GREEN_MASK) >> 5;
    b_f = c & BLUE_MASK;
    rgb[0] = {r_f[4:0], 3'b000};
    rgb[1] = {g_f[5:0], 2'b00};
    rgb[2] = {b_f[4:0], 3'b000};
    return rgb;
  endfunction

  // Floored division by three of a 10-bit sum whose quotient fits in 8 bits.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] prod;
    prod = 21'(x) * RECIP3;
    return prod[RECIP3_SHR +: 8];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cmpr_block_decoder.sv
// Top level of the compressed block decoder: palette pipeline, pixel serializer, output register.
`default_nettype none

// Each input word is one 4x4 block (two RGB565 endpoints and 32 index bits) and
// yields sixteen output words, one pixel each in raster order, with out_last set
// on the sixteenth. A block passes two palette stages and is then loaded into the
// pixel serializer, from which its first pixel goes to the output register. The
// serializer sends one pixel per cycle while out_ready does not stall the output
// register. The next block is taken and its palette built while the current one
// is still being sent, so blocks follow each other with no gap between their
// pixels.
module cmpr_block_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_endpoint_zero,
  input  wire logic [15:0] in_endpoint_one,
  input  wire logic [31:0] in_index_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_pixel_index,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic             out_last
);

  logic                 pal_valid;
  logic                 pal_ready;
  cmpr_pkg::pal_t       pal_data;
  logic [31:0]          pal_idx;

  // Serializer registers.
  logic                 ser_valid_r;
  cmpr_pkg::pal_t       ser_pal_r;
  logic [31:0]          ser_idx_r;
  logic [3:0]           ser_cnt_r;

  // Output register.
  logic                 out_valid_r;
  logic [3:0]           out_pix_r;
  cmpr_pkg::rgb_t       out_rgb_r;
  logic [7:0]           out_alpha_r;
  logic                 out_last_r;

  logic                 out_adv;
  logic                 ser_emit;
  logic                 ser_done;
  logic                 ser_free;
  logic                 ser_load;
  logic [1:0]           sel;
  cmpr_pkg::rgb_t       pix_rgb;
  logic [7:0]           pix_alpha;

  cmpr_palette u_palette (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_endpoint_zero (in_endpoint_zero),
    .in_endpoint_one  (in_endpoint_one),
    .in_index_bits    (in_index_bits),
    .pal_valid        (pal_valid),
    .pal_ready        (pal_ready),
    .pal_data         (pal_data),
    .pal_idx          (pal_idx)
  );

  // Handshake between serializer and output register.
  assign out_adv   = !out_valid_r || out_ready;
  assign ser_emit  = ser_valid_r && out_adv;
  assign ser_done  = ser_emit && (ser_cnt_r == 4'hF);
  assign ser_free  = !ser_valid_r || ser_done;
  assign pal_ready = ser_free;
  assign ser_load  = pal_valid && ser_free;

  // Palette lookup for the current pixel; the index word shifts left per pixel.
  always_comb begin
    sel       = ser_idx_r[31:30];
    pix_rgb   = ser_pal_r.entry[sel];
    pix_alpha = (sel == cmpr_pkg::SEL_ALT) ? ser_pal_r.alpha3 : cmpr_pkg::ALPHA_OPAQUE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      ser_cnt_r   <= 4'd0;
    end else if (ser_load) begin
      ser_valid_r <= 1'b1;
      ser_cnt_r   <= 4'd0;
    end else if (ser_done) begin
      ser_valid_r <= 1'b0;
      ser_cnt_r   <= 4'd0;
    end else if (ser_emit) begin
      ser_cnt_r   <= ser_cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_pal_r <= pal_data;
      ser_idx_r <= pal_idx;
    end else if (ser_emit) begin
      ser_idx_r <= {ser_idx_r[29:0], 2'b00};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= ser_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_emit) begin
      out_pix_r   <= ser_cnt_r;
      out_rgb_r   <= pix_rgb;
      out_alpha_r <= pix_alpha;
      out_last_r  <= ser_cnt_r == 4'hF;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_pix_r;
  assign out_red         = out_rgb_r[0];
  assign out_green       = out_rgb_r[1];
  assign out_blue        = out_rgb_r[2];
  assign out_alpha       = out_alpha_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  // The last flag marks exactly the sixteenth pixel.
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_pixel_index == 4'hF)))
    else $error("last flag does not match pixel position");

  // Within a block, the next pixel follows right after a taken one.
  a_pix_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_pixel_index == $past(out_pixel_index) + 4'd1))
    else $error("pixel sequence broken inside a block");

  // Alpha is either opaque or clear.
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alpha == cmpr_pkg::ALPHA_OPAQUE) ||
                  (out_alpha == cmpr_pkg::ALPHA_CLEAR))
    else $error("alpha is neither opaque nor clear");

  // A palette is taken only when the serializer is idle or finishing.
  a_ser_load: assert property (@(posedge clk) disable iff (!rst_n)
    pal_valid && pal_ready |-> !ser_valid_r || (ser_cnt_r == 4'hF))
    else $error("serializer reloaded mid-block");
`endif

endmodule

`default_nettype wire

FILE: rtl/cmpr_palette.sv
// Two-stage palette builder: endpoint expansion and sums, then the one-third mixes and palette selection.
`default_nettype none

module cmpr_palette (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_endpoint_zero,
  input  wire logic [15:0]        in_endpoint_one,
  input  wire logic [31:0]        in_index_bits,
  output logic                    pal_valid,
  input  wire logic               pal_ready,
  output cmpr_pkg::pal_t          pal_data,
  output logic [31:0]             pal_idx
);

  // Stage 1 registers.
  logic                       s1_valid_r;
  cmpr_pkg::rgb_t             s1_c0_r;
  cmpr_pkg::rgb_t             s1_c1_r;
  cmpr_pkg::rgb_t             s1_avg_r;
  logic [0:2][9:0]            s1_sum2_r;
  logic [0:2][9:0]            s1_sum3_r;
  logic                       s1_gt_r;
  logic [31:0]                s1_idx_r;

  // Stage 2 registers.
  logic                       s2_valid_r;
  cmpr_pkg::pal_t             s2_pal_r;
  logic [31:0]                s2_idx_r;

  logic                       s1_ready;
  logic                       s2_ready;
  logic                       s1_load;
  logic                       s2_load;
  cmpr_pkg::rgb_t             c0_x;
  cmpr_pkg::rgb_t             c1_x;
  cmpr_pkg::rgb_t             avg_x;
  logic [0:2][9:0]            sum2_x;
  logic [0:2][9:0]            sum3_x;
  cmpr_pkg::pal_t             pal_nxt;

  // Elastic handshake: a stage takes a new word when it is empty or its word moves on.
  assign s2_ready = !s2_valid_r || pal_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s1_load  = in_valid && s1_ready;
  assign s2_load  = s1_valid_r && s2_ready;
  assign in_ready = s1_ready;

  // Stage 1 datapath: expansion, weighted sums and the average.
  always_comb begin
    c0_x = cmpr_pkg::expand565(in_endpoint_zero);
    c1_x = cmpr_pkg::expand565(in_endpoint_one);
    for (int ch = 0; ch < 3; ch++) begin
      sum2_x[ch] = {1'b0, c0_x[ch], 1'b0} + {2'b00, c1_x[ch]};
      sum3_x[ch] = {2'b00, c0_x[ch]} + {1'b0, c1_x[ch], 1'b0};
      avg_x[ch]  = 8'(({1'b0, c0_x[ch]} + {1'b0, c1_x[ch]}) >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_c0_r   <= c0_x;
      s1_c1_r   <= c1_x;
      s1_avg_r  <= avg_x;
      s1_sum2_r <= sum2_x;
      s1_sum3_r <= sum3_x;
      s1_gt_r   <= in_endpoint_zero > in_endpoint_one;
      s1_idx_r  <= in_index_bits;
    end
  end

  // Stage 2 datapath: reciprocal divide by three and palette selection.
  always_comb begin
    pal_nxt.entry[cmpr_pkg::SEL_C0] = s1_c0_r;
    pal_nxt.entry[cmpr_pkg::SEL_C1] = s1_c1_r;
    for (int ch = 0; ch < 3; ch++) begin
      pal_nxt.entry[cmpr_pkg::SEL_MIX][ch] =
        s1_gt_r ? cmpr_pkg::div3(s1_sum2_r[ch]) : s1_avg_r[ch];
      pal_nxt.entry[cmpr_pkg::SEL_ALT][ch] = cmpr_pkg::div3(s1_sum3_r[ch]);
    end
    pal_nxt.alpha3 = s1_gt_r ? cmpr_pkg::ALPHA_OPAQUE : cmpr_pkg::ALPHA_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_pal_r <= pal_nxt;
      s2_idx_r <= s1_idx_r;
    end
  end

  assign pal_valid = s2_valid_r;
  assign pal_data  = s2_pal_r;
  assign pal_idx   = s2_idx_r;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for the compressed block decoder: table-driven and random blocks checked pixel by pixel.
`timescale 1ns / 100ps

module tb_top;

  localparam int NUM_DIRECTED = 23;
  localparam int NUM_RANDOM   = 330;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 32;

  // One decoded pixel as it leaves the block.
  typedef struct packed {
    logic [3:0] pos;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } pixel_t;

  // One block of stimulus; when uniform is set every pixel has the color given here.
  typedef struct packed {
    logic [15:0] e0;
    logic [15:0] e1;
    logic [31:0] idx;
    logic        uniform;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
  } block_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_endpoint_zero = '0;
  logic [15:0] in_endpoint_one = '0;
  logic [31:0] in_index_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_pixel_index;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        out_last;

  pixel_t     pending_pixels [$];
  block_row_t dir_rows [NUM_DIRECTED];
  int         stall_pct = 0;
  int         stall_left = 0;
  int         quiet_cycles = 0;
  int         mismatches = 0;
  int         pixels_checked = 0;
  int         clear_pixels = 0;
  int         blocks_sent = 0;
  int         four_color_blocks = 0;

  cmpr_block_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_endpoint_zero (in_endpoint_zero),
    .in_endpoint_one  (in_endpoint_one),
    .in_index_bits    (in_index_bits),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_index  (out_pixel_index),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_last         (out_last)
  );

  always #5 clk = ~clk;

  // Work out the sixteen pixels of one block and queue them.
  function automatic void decode_block(input logic [15:0] e0, input logic [15:0] e1,
                                       input logic [31:0] idx);
    int unsigned c0 [3];
    int unsigned c1 [3];
    logic [7:0]  pal [4][3];
    logic [7:0]  alt_alpha;
    logic [1:0]  sel;
    pixel_t      px;
    // Widen by plain shifts, no bit replication.
    c0[0] = 32'({e0[15:11], 3'b000});
    c0[1] = 32'({e0[10:5], 2'b00});
    c0[2] = 32'({e0[4:0], 3'b000});
    c1[0] = 32'({e1[15:11], 3'b000});
    c1[1] = 32'({e1[10:5], 2'b00});
    c1[2] = 32'({e1[4:0], 3'b000});
    for (int ch = 0; ch < 3; ch++) begin
      pal[cmpr_pkg::SEL_C0][ch] = 8'(c0[ch]);
      pal[cmpr_pkg::SEL_C1][ch] = 8'(c1[ch]);
      if (e0 > e1) begin
        pal[cmpr_pkg::SEL_MIX][ch] = 8'((2 * c0[ch] + c1[ch]) / 3);
      end else begin
        pal[cmpr_pkg::SEL_MIX][ch] = 8'((c0[ch] + c1[ch]) / 2);
      end
      pal[cmpr_pkg::SEL_ALT][ch] = 8'((c0[ch] + 2 * c1[ch]) / 3);
    end
    alt_alpha = (e0 > e1) ? cmpr_pkg::ALPHA_OPAQUE : cmpr_pkg::ALPHA_CLEAR;
    // Pixel p takes its index from the top of the index word downward.
    for (int p = 0; p < 16; p++) begin
      sel = idx[31 - 2 * p -: 2];
      px.pos = 4'(p);
      px.red = pal[sel][0];
      px.green = pal[sel][1];
      px.blue = pal[sel][2];
      px.alpha = (sel == cmpr_pkg::SEL_ALT) ? alt_alpha : cmpr_pkg::ALPHA_OPAQUE;
      px.last = (p == 15);
      pending_pixels.push_back(px);
    end
  endfunction

  // An endpoint at one end of a channel range.
  function automatic logic [15:0] extreme_color();
    case ($urandom_range(4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return cmpr_pkg::RED_MASK;
      3: return cmpr_pkg::GREEN_MASK;
      default: return cmpr_pkg::BLUE_MASK;
    endcase
  endfunction

  // A random block, biased toward equal, neighboring and extreme endpoints.
  function automatic block_row_t random_row();
    block_row_t  row;
    int unsigned pick;
    row = '0;
    pick = $urandom_range(99);
    row.e0 = 16'($urandom);
    row.e1 = 16'($urandom);
    row.idx = $urandom;
    if (pick < 15) begin
      row.e1 = row.e0;
    end else if (pick < 30) begin
      row.e1 = row.e0 + 16'($urandom_range(2)) - 16'd1;
    end else if (pick < 42) begin
      row.e0 = extreme_color();
      row.e1 = extreme_color();
    end
    return row;
  endfunction

  // Drive one block at the falling edge and hold it until it is taken.
  task automatic send_block(input block_row_t row);
    pixel_t px;
    @(negedge clk);
    in_valid <= 1'b1;
    in_endpoint_zero <= row.e0;
    in_endpoint_one <= row.e1;
    in_index_bits <= row.idx;
    do @(posedge clk); while (!in_ready);
    if (row.uniform) begin
      for (int p = 0; p < 16; p++) begin
        px = '{4'(p), row.red, row.green, row.blue, row.alpha, p == 15};
        pending_pixels.push_back(px);
      end
    end else begin
      decode_block(row.e0, row.e1, row.idx);
    end
    blocks_sent++;
    if (row.e0 > row.e1) four_color_blocks++;
  endtask

  // Hold the input idle with junk on the payload.
  task automatic idle_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_endpoint_zero <= 16'($urandom);
      in_endpoint_one <= 16'($urandom);
      in_index_bits <= $urandom;
    end
  endtask

  // Stop sending and wait until every queued pixel has come out.
  task automatic drain_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got, input logic [3:0] pos);
    if (got !== want) begin
      $display("%0t: pixel %0d %s expected %h got %h", $time, pos, name, want, got);
      mismatches++;
    end
  endtask

  // Output ready: random stall bursts of random length.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left <= $urandom_range(18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every accepted pixel with the oldest expectation.
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid && out_ready) begin
        pixels_checked++;
        if (out_alpha == cmpr_pkg::ALPHA_CLEAR) clear_pixels++;
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel %0d expected none got rgba %h%h%h%h", $time,
                   out_pixel_index, out_red, out_green, out_blue, out_alpha);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("index", 8'(want.pos), 8'(out_pixel_index), want.pos);
          check_field("red", want.red, out_red, want.pos);
          check_field("green", want.green, out_green, want.pos);
          check_field("blue", want.blue, out_blue, want.pos);
          check_field("alpha", want.alpha, out_alpha, want.pos);
          check_field("last", 8'(want.last), 8'(out_last), want.pos);
        end
      end
    end
  end

  // Watchdog: no word on either channel for too long.
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no word moved for %0d cycles, %0d pixels still due", $time,
             STALL_LIMIT, pending_pixels.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int gap_pct;
    // Uniform rows have one color in every pixel; the rest go through the predictor.
    dir_rows = '{
      '{16'h0000, 16'h0000, 32'h00000000, 1'b1, 8'h00, 8'h00, 8'h00,
        cmpr_pkg::ALPHA_OPAQUE},
      '{16'h0000, 16'h0000, 32'hFFFFFFFF, 1'b1, 8'h00, 8'h00, 8'h00,
        cmpr_pkg::ALPHA_CLEAR},
      '{16'hFFFF, 16'h0000, 32'h00000000, 1'b1, 8'hF8, 8'hFC, 8'hF8,
        cmpr_pkg::ALPHA_OPAQUE},
      '{16'hFFFF, 16'h0000, 32'h55555555, 1'b1, 8'h00, 8'h00, 8'h00,
        cmpr_pkg::ALPHA_OPAQUE},
      '{16'hFFFF, 16'h0000, 32'hAAAAAAAA, 1'b1, 8'hA5, 8'hA8, 8'hA5,
        cmpr_pkg::ALPHA_OPAQUE},
      '{16'hFFFF, 16'h0000, 32'hFFFFFFFF, 1'b1, 8'h52, 8'h54, 8'h52,
        cmpr_pkg::ALPHA_OPAQUE},
      '{16'hFFFF, 16'hFFFF, 32'hAAAAAAAA, 1'b1, 8'hF8, 8'hFC, 8'hF8,
        cmpr_pkg::ALPHA_OPAQUE},
      '{16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 8'hF8, 8'hFC, 8'hF8,
        cmpr_pkg::ALPHA_CLEAR},
      '{16'h0000, 16'hFFFF, 32'hAAAAAAAA, 1'b1, 8'h7C, 8'h7E, 8'h7C,
        cmpr_pkg::ALPHA_OPAQUE},
      '{16'h0000, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 8'hA5, 8'hA8, 8'hA5,
        cmpr_pkg::ALPHA_CLEAR},
      // Bit 11 is the lowest red bit and bit 8 belongs to green.
      '{16'h0800, 16'h0000, 32'h00000000, 1'b1, 8'h08, 8'h00, 8'h00,
        cmpr_pkg::ALPHA_OPAQUE},
      '{16'h0100, 16'h0000, 32'h00000000, 1'b1, 8'h00, 8'h20, 8'h00,
        cmpr_pkg::ALPHA_OPAQUE},
      '{cmpr_pkg::RED_MASK, 16'h0000, 32'h00000000, 1'b1, 8'hF8, 8'h00, 8'h00,
        cmpr_pkg::ALPHA_OPAQUE},
      '{cmpr_pkg::GREEN_MASK, 16'h0000, 32'h00000000, 1'b1, 8'h00, 8'hFC, 8'h00,
        cmpr_pkg::ALPHA_OPAQUE},
      '{cmpr_pkg::BLUE_MASK, 16'h0000, 32'h00000000, 1'b1, 8'h00, 8'h00, 8'hF8,
        cmpr_pkg::ALPHA_OPAQUE},
      '{16'hFFFF, 16'h0000, 32'h1B1B1B1B, 1'b0, 8'h00, 8'h00, 8'h00,
        cmpr_pkg::ALPHA_CLEAR},
      '{16'h0000, 16'hFFFF, 32'hE4E4E4E4, 1'b0, 8'h00, 8'h00, 8'h00,
        cmpr_pkg::ALPHA_CLEAR},
      // The endpoint order is an unsigned compare.
      '{16'h8000, 16'h7FFF, 32'h1B1B1B1B, 1'b0, 8'h00, 8'h00, 8'h00,
        cmpr_pkg::ALPHA_CLEAR},
      '{16'h7FFF, 16'h8000, 32'h1B1B1B1B, 1'b0, 8'h00, 8'h00, 8'h00,
        cmpr_pkg::ALPHA_CLEAR},
      '{16'h0001, 16'h0000, 32'h6C6C6C6C, 1'b0, 8'h00, 8'h00, 8'h00,
        cmpr_pkg::ALPHA_CLEAR},
      '{16'h0000, 16'h0001, 32'h93939393, 1'b0, 8'h00, 8'h00, 8'h00,
        cmpr_pkg::ALPHA_CLEAR},
      '{16'h1234, 16'h1234, 32'h0123ABCD, 1'b0, 8'h00, 8'h00, 8'h00,
        cmpr_pkg::ALPHA_CLEAR},
      '{16'hF100, 16'h0800, 32'hE4E4E4E4, 1'b0, 8'h00, 8'h00, 8'h00,
        cmpr_pkg::ALPHA_CLEAR}
    };

    // Hold reset, then release it at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed blocks with light idling.
    gap_pct = 20;
    stall_pct = 5;
    foreach (dir_rows[i]) begin
      if ($urandom_range(99) < gap_pct) idle_gap($urandom_range(19, 1));
      send_block(dir_rows[i]);
    end
    drain_pixels();

    // Random blocks: idling, a stretch without it, heavy idling, then none to the end.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 120) begin
        drain_pixels();
        gap_pct = 0;
        stall_pct = 0;
      end else if (i == 200) begin
        gap_pct = 40;
        stall_pct = 12;
      end else if (i == 270) begin
        gap_pct = 0;
        stall_pct = 0;
      end
      if ($urandom_range(99) < gap_pct) idle_gap($urandom_range(19, 1));
      send_block(random_row());
    end
    drain_pixels();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d blocks, %0d with four opaque colors and %0d with a transparent entry.",
             blocks_sent, four_color_blocks, blocks_sent - four_color_blocks);
    $display("Checked %0d pixels, %0d of them transparent; %0d mismatches.",
             pixels_checked, clear_pixels, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
